/* hw/rtl/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/vmbr_pkg.sv */
package vmbr_pkg;

   localparam int MV_W      = 16;
   localparam int STEP_W    = 4;
   localparam int CSR_IDX_W = 2;
   localparam int MIN_KEPT  = 3;

   typedef logic [MV_W-1:0]   mv_type;
   typedef logic [STEP_W-1:0] step_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VALID_MIN = 2'd0,
      CSR_VALID_MAX = 2'd1,
      CSR_WARNING   = 2'd2
   } csr_index_type;

   typedef struct packed {
      mv_type valid_min;
      mv_type valid_max;
      mv_type warning;
   } cfg_type;

   // Datapath operation of one microcode step
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_START,
      OP_COUNT,
      OP_INSERT,
      OP_EMIT_ZERO,
      OP_EMIT_SAMPLE,
      OP_EMIT_MEDIAN
   } op_type;

   // Jump condition of one microcode step
   typedef enum logic [2:0] {
      JMP_ALWAYS,
      JMP_IDLE,
      JMP_COLLECTING,
      JMP_OUT_WINDOW,
      JMP_AT_WARNING,
      JMP_SHIFTING,
      JMP_NOT_LAST,
      JMP_OUT_BUSY
   } cond_type;

   typedef struct packed {
      logic     req_ready;
      op_type   op;
      cond_type cond;
      step_type target;
      logic     last;
   } ctrl_type;

   typedef struct packed {
      logic accept;
      logic collecting;
      logic out_window;
      logic at_warning;
      logic shifting;
      logic not_last;
      logic out_busy;
   } status_type;

   // Program addresses
   localparam step_type ST_FETCH       = 4'd0;
   localparam step_type ST_TEST_COLL   = 4'd1;
   localparam step_type ST_TEST_WIN    = 4'd2;
   localparam step_type ST_TEST_WARN   = 4'd3;
   localparam step_type ST_START       = 4'd4;
   localparam step_type ST_COUNT       = 4'd5;
   localparam step_type ST_TEST_WIN2   = 4'd6;
   localparam step_type ST_INSERT      = 4'd7;
   localparam step_type ST_TEST_LAST   = 4'd8;
   localparam step_type ST_EMIT_MEDIAN = 4'd9;
   localparam step_type ST_EMIT_ZERO   = 4'd10;
   localparam step_type ST_EMIT_SAMPLE = 4'd11;

   // Control store: a taken jump goes to target, otherwise to the next
   // step, or back to fetch when last is set.
   function automatic ctrl_type microcode(input step_type step);
      ctrl_type cw;
      unique case (step)
         ST_FETCH:       cw = '{1'b1, OP_LOAD,        JMP_IDLE,       ST_FETCH,       1'b0};
         ST_TEST_COLL:   cw = '{1'b0, OP_NONE,        JMP_COLLECTING, ST_COUNT,       1'b0};
         ST_TEST_WIN:    cw = '{1'b0, OP_NONE,        JMP_OUT_WINDOW, ST_EMIT_ZERO,   1'b0};
         ST_TEST_WARN:   cw = '{1'b0, OP_NONE,        JMP_AT_WARNING, ST_EMIT_SAMPLE, 1'b0};
         ST_START:       cw = '{1'b0, OP_START,       JMP_ALWAYS,     ST_INSERT,      1'b0};
         ST_COUNT:       cw = '{1'b0, OP_COUNT,       JMP_ALWAYS,     ST_TEST_WIN2,   1'b0};
         ST_TEST_WIN2:   cw = '{1'b0, OP_NONE,        JMP_OUT_WINDOW, ST_TEST_LAST,   1'b0};
         ST_INSERT:      cw = '{1'b0, OP_INSERT,      JMP_SHIFTING,   ST_INSERT,      1'b0};
         ST_TEST_LAST:   cw = '{1'b0, OP_NONE,        JMP_NOT_LAST,   ST_FETCH,       1'b0};
         ST_EMIT_MEDIAN: cw = '{1'b0, OP_EMIT_MEDIAN, JMP_OUT_BUSY,   ST_EMIT_MEDIAN, 1'b1};
         ST_EMIT_ZERO:   cw = '{1'b0, OP_EMIT_ZERO,   JMP_OUT_BUSY,   ST_EMIT_ZERO,   1'b1};
         ST_EMIT_SAMPLE: cw = '{1'b0, OP_EMIT_SAMPLE, JMP_OUT_BUSY,   ST_EMIT_SAMPLE, 1'b1};
         default:        cw = '{1'b0, OP_NONE,        JMP_ALWAYS,     ST_FETCH,       1'b0};
      endcase
      return cw;
   endfunction

endpackage

/* hw/rtl/vmbr_seq.sv */
module vmbr_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  vmbr_pkg::status_type  status,
   output vmbr_pkg::ctrl_type    ctrl
);
   import vmbr_pkg::*;

   step_type pc_ff;
   step_type pc_in;
   logic     jump;

   // Fetch the control word of the current step
   assign ctrl = microcode(pc_ff);

   // Evaluate the jump condition
   always_comb begin
      unique case (ctrl.cond)
         JMP_ALWAYS:     jump = 1'b1;
         JMP_IDLE:       jump = !status.accept;
         JMP_COLLECTING: jump = status.collecting;
         JMP_OUT_WINDOW: jump = status.out_window;
         JMP_AT_WARNING: jump = status.at_warning;
         JMP_SHIFTING:   jump = status.shifting;
         JMP_NOT_LAST:   jump = status.not_last;
         JMP_OUT_BUSY:   jump = status.out_busy;
         default:        jump = 1'b1;
      endcase
   end

   // Advance the step counter
   always_comb begin
      priority if (jump) begin
         pc_in = ctrl.target;
      end else if (ctrl.last) begin
         pc_in = ST_FETCH;
      end else begin
         pc_in = pc_ff + step_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

/* hw/rtl/vmbr_dp.sv */
module vmbr_dp #(
   parameter int SAMPLES = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  vmbr_pkg::ctrl_type   ctrl,
   input  vmbr_pkg::cfg_type    cfg,
   input  logic                 req_valid,
   input  vmbr_pkg::mv_type     req_sample_mv,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output vmbr_pkg::mv_type     rsp_voltage_mv,
   output logic                 rsp_reading_ok,
   output vmbr_pkg::status_type status
);
   import vmbr_pkg::*;

   localparam int IDX_W = $clog2(SAMPLES);
   localparam int CNT_W = $clog2(SAMPLES + 1);

   mv_type             sample_ff;
   mv_type             store_ff [SAMPLES];
   logic               collecting_ff, collecting_in;
   logic [CNT_W-1:0]   taken_ff, taken_in;
   logic [CNT_W-1:0]   kept_ff, kept_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   mv_type             rsp_mv_ff, rsp_mv_in;
   logic               rsp_ok_ff, rsp_ok_in;

   logic [IDX_W-1:0]   rd_addr;
   mv_type             rd_data;
   logic               accept;
   logic               in_window;
   logic               shifting;
   logic               out_busy;
   logic               emit_go;

   assign accept    = req_valid && ctrl.req_ready;
   assign in_window = (sample_ff >= cfg.valid_min) && (sample_ff <= cfg.valid_max);
   assign out_busy  = rsp_valid_ff && !rsp_ready;
   assign emit_go   = !out_busy;

   // Single read port: the neighbor below the hole, or the median entry
   always_comb begin
      priority if (ctrl.op == OP_EMIT_MEDIAN) begin
         rd_addr = IDX_W'(kept_ff >> 1);
      end else if (pos_ff == '0) begin
         rd_addr = '0;
      end else begin
         rd_addr = pos_ff - IDX_W'(1);
      end
   end

   assign rd_data  = store_ff[rd_addr];
   assign shifting = (pos_ff != '0) && (rd_data > sample_ff);

   assign status.accept     = accept;
   assign status.collecting = collecting_ff;
   assign status.out_window = !in_window;
   assign status.at_warning = sample_ff >= cfg.warning;
   assign status.shifting   = shifting;
   assign status.not_last   = taken_ff < CNT_W'(SAMPLES);
   assign status.out_busy   = out_busy;

   // Hold the incoming word
   always_ff @(posedge clock) begin
      if (ctrl.op == OP_LOAD && accept) begin
         sample_ff <= req_sample_mv;
      end
   end

   // Walk the hole down the sorted store, then drop the sample in
   always_ff @(posedge clock) begin
      if (ctrl.op == OP_INSERT) begin
         store_ff[pos_ff] <= shifting ? rd_data : sample_ff;
      end
   end

   // Measurement counters and result register
   always_comb begin
      collecting_in = collecting_ff;
      taken_in      = taken_ff;
      kept_in       = kept_ff;
      pos_in        = pos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_mv_in     = rsp_mv_ff;
      rsp_ok_in     = rsp_ok_ff;
      unique case (ctrl.op)
         OP_START: begin
            collecting_in = 1'b1;
            taken_in      = CNT_W'(1);
            kept_in       = '0;
            pos_in        = '0;
         end
         OP_COUNT: begin
            taken_in = taken_ff + CNT_W'(1);
            pos_in   = IDX_W'(kept_ff);
         end
         OP_INSERT: begin
            if (shifting) begin
               pos_in = pos_ff - IDX_W'(1);
            end else begin
               kept_in = kept_ff + CNT_W'(1);
            end
         end
         OP_EMIT_ZERO: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               rsp_mv_in    = '0;
               rsp_ok_in    = 1'b0;
            end
         end
         OP_EMIT_SAMPLE: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               rsp_mv_in    = sample_ff;
               rsp_ok_in    = 1'b1;
            end
         end
         OP_EMIT_MEDIAN: begin
            if (emit_go) begin
               collecting_in = 1'b0;
               taken_in      = '0;
               kept_in       = '0;
               rsp_valid_in  = 1'b1;
               if (kept_ff < CNT_W'(MIN_KEPT)) begin
                  rsp_mv_in = '0;
                  rsp_ok_in = 1'b0;
               end else begin
                  rsp_mv_in = rd_data;
                  rsp_ok_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
         taken_ff      <= '0;
         kept_ff       <= '0;
         pos_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         collecting_ff <= collecting_in;
         taken_ff      <= taken_in;
         kept_ff       <= kept_in;
         pos_ff        <= pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_mv_ff <= rsp_mv_in;
      rsp_ok_ff <= rsp_ok_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_voltage_mv = rsp_mv_ff;
   assign rsp_reading_ok = rsp_ok_ff;

endmodule

/* hw/rtl/validated_median_battery_reading_top.sv */
// Battery reading filter: takes one millivolt sample per req_ word and gives
// one rsp_ word per finished measurement. A first sample outside the window
// [valid_min, valid_max] is rejected at once (0, not ok); a first sample at
// or above the warning level is reported at once; otherwise SAMPLES-1 more
// samples follow and the median of those inside the window is reported, or a
// rejection when fewer than three were in the window. A small microcoded
// sequencer runs the work; its insert step walks the sorted store one entry
// per cycle. The result sits in an output register, so the next sample is
// taken while a result waits. Write the csr_ registers only while the block
// is idle.
`include "assert_macros.svh"

module validated_median_battery_reading_top #(
   parameter int SAMPLES = 5
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [vmbr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  vmbr_pkg::mv_type                    csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  vmbr_pkg::mv_type                    req_sample_mv,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output vmbr_pkg::mv_type                    rsp_voltage_mv,
   output logic                                rsp_reading_ok
);
   import vmbr_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   ctrl_type   ctrl;
   status_type status;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_VALID_MIN: cfg_in.valid_min = csr_wdata;
            CSR_VALID_MAX: cfg_in.valid_max = csr_wdata;
            CSR_WARNING:   cfg_in.warning   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.valid_min <= mv_type'(2500);
         cfg_ff.valid_max <= mv_type'(5000);
         cfg_ff.warning   <= mv_type'(3500);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   vmbr_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   vmbr_dp #(
      .SAMPLES (SAMPLES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_sample_mv  (req_sample_mv),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_voltage_mv (rsp_voltage_mv),
      .rsp_reading_ok (rsp_reading_ok),
      .status         (status)
   );

   assign req_ready = ctrl.req_ready;

   // A rejection always carries zero volts
   `ASSERT_IMPLY(a_reject_zero, clock, reset, rsp_valid && !rsp_reading_ok, rsp_voltage_mv == '0, "rejected word with nonzero voltage")
   // A new result only comes from an emit step
   `ASSERT_IMPLY(a_emit_source, clock, reset, $rose(rsp_valid), $past(ctrl.op) == OP_EMIT_ZERO || $past(ctrl.op) == OP_EMIT_SAMPLE || $past(ctrl.op) == OP_EMIT_MEDIAN, "result without emit step")
   // A sample is processed before the next one is taken
   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "sample taken while busy")

endmodule
